FILE: rtl/core/thhe_pkg.sv
`timescale 1ns / 1ps

package thhe_pkg;

	localparam int HASH_BYTES     = 20;
	localparam int RESERVED_BYTES = 8;
	localparam int IDENT_LEN      = 19;
	localparam int HASH_START     = 1 + IDENT_LEN + RESERVED_BYTES;
	localparam int FULL_LEN       = HASH_START + HASH_BYTES;
	localparam int POS_W          = $clog2(FULL_LEN + 1);
	localparam int HIDX_W         = 5;

	localparam logic [7:0] UDP_PROTO = 8'h11;
	localparam logic [7:0] LEN_BYTE  = 8'(IDENT_LEN);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef struct packed {
		logic step;
		logic next;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a)
			return c + 8'd32;
		return c;
	endfunction

	// lower-case ident text, "bittorrent protocol"
	function automatic logic [7:0] ident_char(input logic [4:0] i);
		case (i)
			5'd0:    return 8'h62;
			5'd1:    return 8'h69;
			5'd2:    return 8'h74;
			5'd3:    return 8'h74;
			5'd4:    return 8'h6f;
			5'd5:    return 8'h72;
			5'd6:    return 8'h72;
			5'd7:    return 8'h65;
			5'd8:    return 8'h6e;
			5'd9:    return 8'h74;
			5'd10:   return 8'h20;
			5'd11:   return 8'h70;
			5'd12:   return 8'h72;
			5'd13:   return 8'h6f;
			5'd14:   return 8'h74;
			5'd15:   return 8'h6f;
			5'd16:   return 8'h63;
			5'd17:   return 8'h6f;
			5'd18:   return 8'h6c;
			default: return 8'h00;
		endcase
	endfunction

endpackage

FILE: rtl/core/thhe_in_if.sv
`timescale 1ns / 1ps

interface thhe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       packet_end;
	logic [7:0] ip_protocol;

	modport source (output valid, output payload_byte, output packet_end,
		output ip_protocol, input ready);
	modport sink (input valid, input payload_byte, input packet_end,
		input ip_protocol, output ready);
endinterface

FILE: rtl/core/thhe_out_if.sv
`timescale 1ns / 1ps

interface thhe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] hash_byte;
	logic [4:0] hash_index;
	logic       run_last;
	logic       ident_matched;
	logic       hash_valid;

	modport source (output valid, output hash_byte, output hash_index,
		output run_last, output ident_matched, output hash_valid, input ready);
	modport sink (input valid, input hash_byte, input hash_index,
		input run_last, input ident_matched, input hash_valid, output ready);
endinterface

FILE: rtl/core/torrent_handshake_hash_extractor_unit.sv
`timescale 1ns / 1ps

// payload bytes enter on in_ch, one word per accepted handshake, each with
// its packet_end mark and the packet's ip protocol number
// results leave on out_ch: on the word carrying packet_end the block gives
// either one word (ident not matched, UDP protocol, or packet too short for the hash)
// or 20 words holding the info hash, run_last set on the final one
// a byte without packet_end is accepted and gives nothing
// the first result is shown the cycle after the end word is accepted, and
// each further hash word is shown in the cycle after the previous is taken
// while results are being delivered in_ch.ready stays low, so the next
// packet starts once the last result word has been taken
// a stall on out_ch holds the current result word steady and delays the rest
// reset clears the byte position and the per-packet checks and returns the
// controller to accepting input; the hash store itself is not cleared
module torrent_handshake_hash_extractor_unit (
	input logic        clk,
	input logic        arst_n,
	thhe_in_if.sink    in_ch,
	thhe_out_if.source out_ch
);

	thhe_pkg::ctrl_cmd_t cmd;
	thhe_pkg::dp_stat_t  stat;

	thhe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_end    (in_ch.packet_end),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	thhe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.payload_byte  (in_ch.payload_byte),
		.packet_end    (in_ch.packet_end),
		.ip_protocol   (in_ch.ip_protocol),
		.hash_byte     (out_ch.hash_byte),
		.hash_index    (out_ch.hash_index),
		.run_last      (out_ch.run_last),
		.ident_matched (out_ch.ident_matched),
		.hash_valid    (out_ch.hash_valid)
	);

endmodule

FILE: rtl/core/thhe_ctrl.sv
`timescale 1ns / 1ps

module thhe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output thhe_pkg::ctrl_cmd_t cmd,
	input  thhe_pkg::dp_stat_t  stat
);

	thhe_pkg::state_t state_q;
	thhe_pkg::state_t state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			thhe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.step = in_valid;
				if (in_valid && in_end)
					state_d = thhe_pkg::ST_EMIT;
			end
			thhe_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last)
						state_d = thhe_pkg::ST_IDLE;
					else
						cmd.next = 1'b1;
				end
			end
			default: begin
				state_d = thhe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= thhe_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/core/thhe_dp.sv
`timescale 1ns / 1ps

module thhe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  thhe_pkg::ctrl_cmd_t cmd,
	output thhe_pkg::dp_stat_t  stat,
	input  logic [7:0]          payload_byte,
	input  logic                packet_end,
	input  logic [7:0]          ip_protocol,
	output logic [7:0]          hash_byte,
	output logic [4:0]          hash_index,
	output logic                run_last,
	output logic                ident_matched,
	output logic                hash_valid
);

	localparam logic [thhe_pkg::POS_W-1:0] POS_IDENT = thhe_pkg::POS_W'(thhe_pkg::IDENT_LEN);
	localparam logic [thhe_pkg::POS_W-1:0] POS_HASH  = thhe_pkg::POS_W'(thhe_pkg::HASH_START);
	localparam logic [thhe_pkg::POS_W-1:0] POS_FULL  = thhe_pkg::POS_W'(thhe_pkg::FULL_LEN);
	localparam logic [thhe_pkg::HIDX_W-1:0] IDX_LAST =
		thhe_pkg::HIDX_W'(thhe_pkg::HASH_BYTES - 1);

	logic [thhe_pkg::POS_W-1:0]  pos_q;
	logic                        ok_q;
	logic [7:0]                  store_q [thhe_pkg::HASH_BYTES];
	logic [7:0]                  hbyte_q;
	logic [thhe_pkg::HIDX_W-1:0] hidx_q;
	logic                        last_q;
	logic                        matched_q;
	logic                        valid_q;

	logic [thhe_pkg::POS_W-1:0]  pos_next;
	logic [thhe_pkg::POS_W-1:0]  hoff;
	logic [thhe_pkg::HIDX_W-1:0] widx;
	logic [thhe_pkg::HIDX_W-1:0] nidx;
	logic [4:0]                  cidx;
	logic                        in_hash;
	logic                        ok_next;
	logic                        matched;
	logic                        valid;
	logic [7:0]                  first_byte;

	always_comb begin
		hoff     = pos_q - POS_HASH;
		widx     = hoff[thhe_pkg::HIDX_W-1:0];
		in_hash  = (pos_q >= POS_HASH) && (pos_q < POS_FULL);
		cidx     = pos_q[4:0] - 5'd1;
		pos_next = (pos_q < POS_FULL) ? pos_q + 1'b1 : pos_q;
		ok_next  = ok_q && (ip_protocol != thhe_pkg::UDP_PROTO);
		if (pos_q == '0) begin
			if (payload_byte != thhe_pkg::LEN_BYTE)
				ok_next = 1'b0;
		end else if (pos_q <= POS_IDENT) begin
			if (thhe_pkg::fold_case(payload_byte) != thhe_pkg::ident_char(cidx))
				ok_next = 1'b0;
		end
		matched = ok_next && (pos_next > POS_IDENT);
		valid   = matched && (pos_next >= POS_FULL);
		// entry zero may be written by this very byte
		first_byte = (in_hash && widx == '0) ? payload_byte : store_q[0];
		nidx       = hidx_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ok_q  <= 1'b1;
		end else if (cmd.step) begin
			if (packet_end) begin
				pos_q <= '0;
				ok_q  <= 1'b1;
			end else begin
				pos_q <= pos_next;
				ok_q  <= ok_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && in_hash)
			store_q[widx] <= payload_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.step && packet_end) begin
			hbyte_q   <= valid ? first_byte : 8'd0;
			hidx_q    <= '0;
			last_q    <= !valid || (IDX_LAST == '0);
			matched_q <= matched;
			valid_q   <= valid;
		end else if (cmd.next) begin
			hbyte_q <= store_q[nidx];
			hidx_q  <= nidx;
			last_q  <= (nidx == IDX_LAST);
		end
	end

	assign stat.last     = last_q;
	assign hash_byte     = hbyte_q;
	assign hash_index    = 5'(hidx_q);
	assign run_last      = last_q;
	assign ident_matched = matched_q;
	assign hash_valid    = valid_q;

endmodule
